// ----- sv/rtphi_pkg.sv -----
// Shared types and constants for the RTP header inserter.
// No dependencies; the front end, queue, back end and core modules import this package.
package rtphi_pkg;

   localparam int HDR_LEN      = 12;
   localparam int HDR_IDX_W    = $clog2(HDR_LEN);
   localparam logic [HDR_IDX_W-1:0] HDR_LAST_IDX = HDR_IDX_W'(HDR_LEN - 1);
   localparam logic [7:0] RTP_VERSION_BYTE = 8'h80;

   localparam int FIFO_DEPTH   = 4;
   localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W   = $clog2(FIFO_DEPTH + 1);

   localparam int CSR_INDEX_W  = 4;
   localparam int CSR_DATA_W   = 32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PAYLOAD_TYPE = 4'd0,
      CSR_TS_STEP      = 4'd1,
      CSR_SSRC         = 4'd2,
      CSR_SINK_EN      = 4'd3
   } csr_idx_type;

   // Header byte positions within the fixed header
   typedef enum logic [HDR_IDX_W-1:0] {
      HB_VERSION = 4'd0,
      HB_PTYPE   = 4'd1,
      HB_SEQ_HI  = 4'd2,
      HB_SEQ_LO  = 4'd3,
      HB_TS_3    = 4'd4,
      HB_TS_2    = 4'd5,
      HB_TS_1    = 4'd6,
      HB_TS_0    = 4'd7,
      HB_SSRC_3  = 4'd8,
      HB_SSRC_2  = 4'd9,
      HB_SSRC_1  = 4'd10,
      HB_SSRC_0  = 4'd11
   } hdr_byte_type;

   // One classified item waiting for the back end
   typedef struct packed {
      logic       send_hdr;
      logic       has_byte;
      logic       eop;
      logic [7:0] data;
   } cmd_type;

   // Header configuration seen by the back end
   typedef struct packed {
      logic [6:0]  payload_type;
      logic [15:0] ts_step;
      logic [31:0] ssrc;
   } hdr_cfg_type;

endpackage

// ----- sv/rtphi_req_if.sv -----
// Input channel of the RTP header inserter: at most one payload byte per item.
// No dependencies.
interface rtphi_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] payload_byte;
   logic       has_byte;
   logic       end_of_packet;

   modport source (output valid, output payload_byte, output has_byte,
                   output end_of_packet, input ready);
   modport sink   (input valid, input payload_byte, input has_byte,
                   input end_of_packet, output ready);
endinterface

// ----- sv/rtphi_rsp_if.sv -----
// Output channel of the RTP header inserter: one header or payload byte per item.
// No dependencies.
interface rtphi_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       is_header;
   logic       packet_last;

   modport source (output valid, output out_byte, output is_header,
                   output packet_last, input ready);
   modport sink   (input valid, input out_byte, input is_header,
                   input packet_last, output ready);
endinterface

// ----- sv/rtphi_front.sv -----
// Front end: accepts input items, tracks packet boundaries, queues commands.
// Depends on rtphi_pkg and rtphi_req_if.
module rtphi_front (
   input  logic             clock,
   input  logic             reset,
   rtphi_req_if.sink        req_ch,
   input  logic             sink_en,
   input  logic             queue_full,
   output logic             push,
   output rtphi_pkg::cmd_type cmd
);
   import rtphi_pkg::*;

   logic inside_ff;
   logic inside_in;
   logic accept;
   logic active;

   assign req_ch.ready = !queue_full;
   assign accept       = req_ch.valid && req_ch.ready;
   assign active       = req_ch.has_byte || req_ch.end_of_packet;

   // Drop idle items, disabled-sink items and bare ends inside a packet
   assign push = accept && sink_en && active &&
                 !(!req_ch.has_byte && inside_ff);

   assign cmd.send_hdr = !inside_ff;
   assign cmd.has_byte = req_ch.has_byte;
   assign cmd.eop      = req_ch.end_of_packet;
   assign cmd.data     = req_ch.payload_byte;

   always_comb begin
      inside_in = inside_ff;
      if (accept) begin
         if (!sink_en) begin
            inside_in = 1'b0;
         end else if (active) begin
            inside_in = req_ch.has_byte && !req_ch.end_of_packet;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_ff <= 1'b0;
      end else begin
         inside_ff <= inside_in;
      end
   end

   a_disabled_closes: assert property (@(posedge clock) disable iff (reset)
      accept && !sink_en |=> !inside_ff)
      else $error("packet left open after a disabled-sink item");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !queue_full)
      else $error("command pushed into a full queue");

   a_header_only_at_start: assert property (@(posedge clock) disable iff (reset)
      push && inside_ff |-> req_ch.has_byte)
      else $error("byte-less command issued inside a packet");

endmodule

// ----- sv/rtphi_fifo.sv -----
// Short command queue between the front and back ends.
// Depends on rtphi_pkg.
module rtphi_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  rtphi_pkg::cmd_type push_cmd,
   input  logic               pop,
   output logic               full,
   output logic               head_valid,
   output rtphi_pkg::cmd_type head_cmd
);
   import rtphi_pkg::*;

   cmd_type                entry_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0]  count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   assign full       = count_ff == FIFO_CNT_W'(FIFO_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_cmd   = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FIFO_CNT_W'(FIFO_DEPTH))
      else $error("queue count out of range");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      FIFO_PTR_W'(wr_ptr_ff - rd_ptr_ff) == FIFO_PTR_W'(count_ff))
      else $error("queue pointers disagree with count");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from an empty queue");

endmodule

// ----- sv/rtphi_back.sv -----
// Back end: expands queued commands into header and payload bytes, owns the
// sequence and timestamp counters. Depends on rtphi_pkg and rtphi_rsp_if.
module rtphi_back (
   input  logic                   clock,
   input  logic                   reset,
   input  rtphi_pkg::hdr_cfg_type cfg,
   input  logic                   head_valid,
   input  rtphi_pkg::cmd_type     head_cmd,
   output logic                   pop,
   rtphi_rsp_if.source            rsp_ch
);
   import rtphi_pkg::*;

   logic [HDR_IDX_W-1:0] idx_ff, idx_in;
   logic                 hdr_done_ff, hdr_done_in;
   logic [15:0]          seq_ff, seq_in;
   logic [31:0]          ts_ff, ts_in;
   logic                 valid_ff, valid_in;
   logic [7:0]           byte_ff, byte_in;
   logic                 hdr_flag_ff, hdr_flag_in;
   logic                 last_ff, last_in;
   logic                 can_load;
   logic                 load;
   logic                 in_hdr;
   logic                 hdr_end;
   logic [7:0]           hdr_byte;

   assign can_load = !valid_ff || rsp_ch.ready;
   assign load     = can_load && head_valid;
   assign in_hdr   = head_cmd.send_hdr && !hdr_done_ff;
   assign hdr_end  = in_hdr && idx_ff == HDR_LAST_IDX;
   assign pop      = load && (!in_hdr || (hdr_end && !head_cmd.has_byte));

   always_comb begin
      case (hdr_byte_type'(idx_ff))
         HB_VERSION: hdr_byte = RTP_VERSION_BYTE;
         HB_PTYPE:   hdr_byte = {1'b0, cfg.payload_type};
         HB_SEQ_HI:  hdr_byte = seq_ff[15:8];
         HB_SEQ_LO:  hdr_byte = seq_ff[7:0];
         HB_TS_3:    hdr_byte = ts_ff[31:24];
         HB_TS_2:    hdr_byte = ts_ff[23:16];
         HB_TS_1:    hdr_byte = ts_ff[15:8];
         HB_TS_0:    hdr_byte = ts_ff[7:0];
         HB_SSRC_3:  hdr_byte = cfg.ssrc[31:24];
         HB_SSRC_2:  hdr_byte = cfg.ssrc[23:16];
         HB_SSRC_1:  hdr_byte = cfg.ssrc[15:8];
         HB_SSRC_0:  hdr_byte = cfg.ssrc[7:0];
         default:    hdr_byte = '0;
      endcase
   end

   always_comb begin
      idx_in      = idx_ff;
      hdr_done_in = hdr_done_ff;
      seq_in      = seq_ff;
      ts_in       = ts_ff;
      valid_in    = valid_ff && !rsp_ch.ready;
      byte_in     = byte_ff;
      hdr_flag_in = hdr_flag_ff;
      last_in     = last_ff;
      if (load) begin
         valid_in = 1'b1;
         if (in_hdr) begin
            byte_in     = hdr_byte;
            hdr_flag_in = 1'b1;
            last_in     = hdr_end && !head_cmd.has_byte;
            if (hdr_end) begin
               // Advance counters once the whole header is out
               idx_in      = '0;
               hdr_done_in = head_cmd.has_byte;
               seq_in      = seq_ff + 16'd1;
               ts_in       = ts_ff + {16'd0, cfg.ts_step};
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end else begin
            byte_in     = head_cmd.data;
            hdr_flag_in = 1'b0;
            last_in     = head_cmd.eop;
            hdr_done_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff      <= '0;
         hdr_done_ff <= 1'b0;
         seq_ff      <= '0;
         ts_ff       <= '0;
         valid_ff    <= 1'b0;
      end else begin
         idx_ff      <= idx_in;
         hdr_done_ff <= hdr_done_in;
         seq_ff      <= seq_in;
         ts_ff       <= ts_in;
         valid_ff    <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff     <= byte_in;
      hdr_flag_ff <= hdr_flag_in;
      last_ff     <= last_in;
   end

   assign rsp_ch.valid       = valid_ff;
   assign rsp_ch.out_byte    = byte_ff;
   assign rsp_ch.is_header   = hdr_flag_ff;
   assign rsp_ch.packet_last = last_ff;

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= HDR_LAST_IDX)
      else $error("header index past the last header byte");

   a_seq_advance: assert property (@(posedge clock) disable iff (reset)
      load && hdr_end |=> seq_ff == $past(seq_ff) + 16'd1)
      else $error("sequence number did not advance after a header");

   a_idx_zero_in_payload: assert property (@(posedge clock) disable iff (reset)
      hdr_done_ff |-> idx_ff == '0)
      else $error("header index left nonzero during payload");

endmodule

// ----- sv/rtp_header_inserter_core.sv -----
// RTP fixed-header inserter. Each packet of payload bytes (req_ch, end_of_packet on
// the last one) leaves on rsp_ch prefixed by a 12-byte RTP header: 0x80, payload type,
// sequence number, timestamp and SSRC, most significant byte first; sequence and
// timestamp advance after every header. A payload byte inside a packet yields one output
// byte; the first item of a packet yields the header bytes and then its own byte, if it
// has one, all from the single output byte register. A four-entry command queue lets the
// input keep flowing while header bytes drain. Registers (csr_index): 0 payload type,
// 1 timestamp step, 2 SSRC, 3 sink enable; write them only while the block is idle.
module rtp_header_inserter_core (
   input  logic                                  clock,
   input  logic                                  reset,
   rtphi_req_if.sink                             req_ch,
   rtphi_rsp_if.source                           rsp_ch,
   input  logic                                  csr_wr_en,
   input  logic [rtphi_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [rtphi_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import rtphi_pkg::*;

   logic [6:0]  ptype_ff;
   logic [15:0] ts_step_ff;
   logic [31:0] ssrc_ff;
   logic        sink_en_ff;

   hdr_cfg_type hdr_cfg;
   cmd_type     push_cmd;
   cmd_type     head_cmd;
   logic        push;
   logic        pop;
   logic        queue_full;
   logic        head_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         ptype_ff   <= 7'd0;
         ts_step_ff <= 16'd160;
         ssrc_ff    <= 32'd10;
         sink_en_ff <= 1'b1;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_PAYLOAD_TYPE: ptype_ff   <= csr_wdata[6:0];
            CSR_TS_STEP:      ts_step_ff <= csr_wdata[15:0];
            CSR_SSRC:         ssrc_ff    <= csr_wdata[31:0];
            CSR_SINK_EN:      sink_en_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign hdr_cfg.payload_type = ptype_ff;
   assign hdr_cfg.ts_step      = ts_step_ff;
   assign hdr_cfg.ssrc         = ssrc_ff;

   rtphi_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .sink_en    (sink_en_ff),
      .queue_full (queue_full),
      .push       (push),
      .cmd        (push_cmd)
   );

   rtphi_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   rtphi_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (hdr_cfg),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .rsp_ch     (rsp_ch)
   );

endmodule
